// ===== hdl/mstk_pkg.sv =====
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared types and constants for the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
package mstk_pkg;

    // Width and ceiling of the amount field (edge weight or tree cost)
    localparam int unsigned AMOUNT_W = 19;
    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 19'h7FFFF;

    // Width of the vertex_count register
    localparam int unsigned VCOUNT_W = 5;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

    // Output field widths
    localparam int unsigned VTX_OUT_W = 4;

    // Result kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_COST = 1'b1;

    // Main sequencer
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_PICK,
        S_FIND,
        S_EMIT_EDGE,
        S_MERGE,
        S_EMIT_COST
    } t_state;

    // Commands to the label unit
    typedef enum logic [1:0] {
        LAB_NOP,
        LAB_FIND,
        LAB_MERGE,
        LAB_CLEAR
    } t_lab_cmd;

    // Label unit sequencer
    typedef enum logic [2:0] {
        L_IDLE,
        L_RDB,
        L_CMP,
        L_SWEEP,
        L_TAIL
    } t_lab_state;

endpackage

// ===== hdl/mstk_in_if.sv =====
// ----------------------------------------------------------------------------
// mstk_in_if
// Request channel carrying one matrix entry.
// ----------------------------------------------------------------------------
interface mstk_in_if #(
    parameter int unsigned WEIGHT_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [WEIGHT_BITS-1:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

// ===== hdl/mstk_out_if.sv =====
// ----------------------------------------------------------------------------
// mstk_out_if
// Result channel: tree edges followed by the total cost.
// ----------------------------------------------------------------------------
interface mstk_out_if;
    import mstk_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [VTX_OUT_W-1:0]  vertex_a;
    logic [VTX_OUT_W-1:0]  vertex_b;
    logic [AMOUNT_W-1:0]   amount;
    logic                  last;

    modport source (output valid, output kind, output vertex_a, output vertex_b,
                    output amount, output last, input ready);
    modport sink   (input valid, input kind, input vertex_a, input vertex_b,
                    input amount, input last, output ready);
endinterface

// ===== hdl/mstk_select.sv =====
// ----------------------------------------------------------------------------
// mstk_select
// Shared key comparator: tracks the smallest edge key above the last pick.
// ----------------------------------------------------------------------------
module mstk_select
    import mstk_pkg::*;
#(
    parameter int unsigned KEY_W = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_commit,
    input  logic             i_cand_vld,
    input  logic [KEY_W-1:0] i_cand_key,
    output logic             o_best_vld,
    output logic [KEY_W-1:0] o_best_key
);

    logic [KEY_W-1:0] r_best_key;
    logic [KEY_W-1:0] r_prev_key;
    logic             r_best_vld;
    logic             r_have_prev;
    logic             above;
    logic             below;

    assign above = !r_have_prev || (i_cand_key > r_prev_key);
    assign below = !r_best_vld || (i_cand_key < r_best_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld  <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_start) begin
            r_best_vld  <= 1'b0;
            r_have_prev <= 1'b0;
        end else if (i_commit) begin
            r_best_vld  <= 1'b0;
            r_have_prev <= 1'b1;
        end else if (i_cand_vld && above && below) begin
            r_best_vld  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_prev_key <= r_best_key;
        end
        if (!i_start && !i_commit && i_cand_vld && above && below) begin
            r_best_key <= i_cand_key;
        end
    end

    assign o_best_vld = r_best_vld;
    assign o_best_key = r_best_key;

endmodule

// ===== hdl/mstk_label.sv =====
// ----------------------------------------------------------------------------
// mstk_label
// Set label memory: looks up two vertex labels, relabels one set on a merge.
// ----------------------------------------------------------------------------
module mstk_label
    import mstk_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned VW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_lab_cmd      i_cmd,
    input  logic [VW-1:0] i_va,
    input  logic [VW-1:0] i_vb,
    input  logic [VW-1:0] i_nm1,
    output logic          o_done,
    output logic          o_same
);

    logic [VW-1:0] r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_vld;

    t_lab_state r_state;
    t_lab_state n_state;

    logic [VW-1:0] r_rd;
    logic [VW-1:0] r_rd_idx;
    logic          r_rd_ok;
    logic [VW-1:0] r_vb;
    logic [VW-1:0] r_la;
    logic [VW-1:0] r_lb;
    logic [VW-1:0] r_v;
    logic          r_pv;
    logic [VW-1:0] rd_addr;
    logic [VW-1:0] label;
    logic          wr_en;

    // unwritten entry is its own label
    assign label = r_rd_ok ? r_rd : r_rd_idx;
    assign wr_en = r_pv && (label == r_la);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: begin
                priority if (i_cmd == LAB_FIND) n_state = L_RDB;
                else if (i_cmd == LAB_MERGE)    n_state = L_SWEEP;
                else                            n_state = L_IDLE;
            end
            L_RDB:   n_state = L_CMP;
            L_CMP:   n_state = L_IDLE;
            L_SWEEP: begin
                if (r_v == i_nm1) n_state = L_TAIL;
            end
            L_TAIL:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_comb begin
        rd_addr = i_va;
        o_done  = 1'b0;
        unique case (r_state)
            L_IDLE:  rd_addr = i_va;
            L_RDB:   rd_addr = r_vb;
            L_CMP:   o_done  = 1'b1;
            L_SWEEP: rd_addr = r_v;
            L_TAIL:  o_done  = 1'b1;
            default: rd_addr = i_va;
        endcase
    end

    assign o_same = (r_la == label);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_vld   <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == L_SWEEP);
            if (i_cmd == LAB_CLEAR) begin
                r_vld <= '0;
            end else if (wr_en) begin
                r_vld[r_rd_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd     <= r_mem[rd_addr];
        r_rd_idx <= rd_addr;
        r_rd_ok  <= r_vld[rd_addr];
        if (wr_en) begin
            r_mem[r_rd_idx] <= r_lb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE && i_cmd == LAB_FIND) begin
            r_vb <= i_vb;
        end
        if (r_state == L_RDB) begin
            r_la <= label;
        end
        if (r_state == L_CMP) begin
            r_lb <= label;
        end
        if (r_state == L_IDLE) begin
            r_v <= '0;
        end else if (r_state == L_SWEEP) begin
            r_v <= r_v + VW'(1);
        end
    end

endmodule

// ===== hdl/minimum_spanning_tree_kruskal.sv =====
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal spanning tree over a streamed adjacency matrix, with set labels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        weight (one matrix entry, row-major)
//  o_out     out  valid/ready        kind, vertex_a, vertex_b, amount, last
//  cfg       in   i_cfg_we           i_cfg_wdata = vertex_count
//
// Entries load one per cycle. Each edge taken in key order costs a comparator
// pass over the matrix and a label lookup; a tree edge adds its result and a
// relabel sweep. A last pass and the cost result close the run; i_in.ready is
// low throughout the solve. Reset is synchronous; no clearing pass is needed.
// A stalled o_out holds the sequencer at the emit states; internal work does
// not advance meanwhile.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal
    import mstk_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned WEIGHT_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [VCOUNT_W-1:0] i_cfg_wdata,
    mstk_in_if.sink             i_in,
    mstk_out_if.source          o_out
);

    localparam int unsigned VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
    localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = AW + 1;
    localparam int unsigned KEY_W = WEIGHT_BITS + 2 * VW;
    localparam int unsigned XW    = (VW > VTX_OUT_W) ? VW : VTX_OUT_W;
    localparam int unsigned EW    = (WEIGHT_BITS > AMOUNT_W) ? WEIGHT_BITS : AMOUNT_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic [VCOUNT_W-1:0]    r_vcount;
    logic [CW-1:0]          r_load_cnt;
    logic [WEIGHT_BITS-1:0] r_wmem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_rdata;
    logic [AW-1:0]          r_raddr;
    logic [VW-1:0]          r_row;
    logic [VW-1:0]          r_col;
    logic                   r_pv;
    logic [VW-1:0]          r_prow;
    logic [VW-1:0]          r_pcol;
    logic [AMOUNT_W-1:0]    r_cost;

    // output register
    logic                   r_ovalid;
    logic                   r_okind;
    logic [VTX_OUT_W-1:0]   r_oa;
    logic [VTX_OUT_W-1:0]   r_ob;
    logic [AMOUNT_W-1:0]    r_oamt;
    logic                   r_olast;

    // ------------------------------------------------------------------
    // effective vertex count: zero acts as one, clamp to the array size
    // ------------------------------------------------------------------
    logic [NW-1:0] n;
    logic [VW-1:0] nm1;
    logic [CW-1:0] nsq;

    always_comb begin
        priority if (r_vcount == '0)                      n = NW'(1);
        else if (32'(r_vcount) > 32'(MAX_VERTICES))       n = NW'(MAX_VERTICES);
        else                                              n = NW'(r_vcount);
    end
    assign nm1 = VW'(n - NW'(1));
    assign nsq = CW'(n) * CW'(n);

    // ------------------------------------------------------------------
    // candidate edges from the RAM read port
    // ------------------------------------------------------------------
    logic             cand_vld;
    logic [KEY_W-1:0] cand_key;
    logic             best_vld;
    logic [KEY_W-1:0] best_key;
    logic [WEIGHT_BITS-1:0] best_w;
    logic [VW-1:0]    best_a;
    logic [VW-1:0]    best_b;

    // only strictly-upper entries with a positive weight are edges
    assign cand_vld = r_pv && (r_pcol > r_prow) && (r_rdata != '0)
                      && !r_rdata[WEIGHT_BITS-1];
    assign cand_key = {r_rdata, r_prow, r_pcol};

    assign best_w = best_key[KEY_W-1 -: WEIGHT_BITS];
    assign best_a = best_key[2*VW-1 -: VW];
    assign best_b = best_key[VW-1:0];

    // ------------------------------------------------------------------
    // sequencer controls
    // ------------------------------------------------------------------
    logic     out_free;
    logic     in_acc;
    logic     load_done;
    logic     scan_end;
    logic     sel_start;
    logic     sel_commit;
    logic     load_edge;
    logic     load_cost;
    t_lab_cmd lab_cmd;
    logic     lab_done;
    logic     lab_same;

    assign out_free  = !r_ovalid || o_out.ready;
    assign in_acc    = i_in.valid && i_in.ready;
    assign load_done = in_acc && ((r_load_cnt + CW'(1)) == nsq);
    assign scan_end  = (r_row == nm1) && (r_col == nm1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:      if (load_done) n_state = S_SCAN;
            S_SCAN:      if (scan_end) n_state = S_DRAIN;
            S_DRAIN:     n_state = S_PICK;
            S_PICK:      n_state = best_vld ? S_FIND : S_EMIT_COST;
            S_FIND: begin
                if (lab_done) n_state = lab_same ? S_SCAN : S_EMIT_EDGE;
            end
            S_EMIT_EDGE: if (out_free) n_state = S_MERGE;
            S_MERGE:     if (lab_done) n_state = S_SCAN;
            S_EMIT_COST: if (out_free) n_state = S_LOAD;
            default:     n_state = S_LOAD;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        sel_start  = 1'b0;
        sel_commit = 1'b0;
        load_edge  = 1'b0;
        load_cost  = 1'b0;
        lab_cmd    = LAB_NOP;
        unique case (r_state)
            S_LOAD: begin
                i_in.ready = 1'b1;
                sel_start  = load_done;
            end
            S_SCAN, S_DRAIN: ;
            S_PICK:  if (best_vld) lab_cmd = LAB_FIND;
            S_FIND:  sel_commit = lab_done && lab_same;
            S_EMIT_EDGE: begin
                if (out_free) begin
                    load_edge = 1'b1;
                    lab_cmd   = LAB_MERGE;
                end
            end
            S_MERGE: sel_commit = lab_done;
            S_EMIT_COST: begin
                if (out_free) begin
                    load_cost = 1'b1;
                    lab_cmd   = LAB_CLEAR;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // saturating cost accumulate
    // ------------------------------------------------------------------
    logic [EW-1:0]       w_ext;
    logic [EW-1:0]       headroom;
    logic [AMOUNT_W-1:0] cost_next;
    logic [XW-1:0]       a_ext;
    logic [XW-1:0]       b_ext;

    assign w_ext     = EW'(best_w);
    assign headroom  = EW'(AMOUNT_MAX - r_cost);
    assign cost_next = (w_ext >= headroom) ? AMOUNT_MAX : (r_cost + w_ext[AMOUNT_W-1:0]);
    assign a_ext     = XW'(best_a);
    assign b_ext     = XW'(best_b);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_vcount   <= VCOUNT_RST;
            r_load_cnt <= '0;
            r_cost     <= '0;
            r_ovalid   <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_vcount   <= i_cfg_wdata;
                r_load_cnt <= '0;
            end else if (load_done) begin
                r_load_cnt <= '0;
            end else if (in_acc) begin
                r_load_cnt <= r_load_cnt + CW'(1);
            end
            if (load_cost) begin
                r_cost <= '0;
            end else if (load_edge) begin
                r_cost <= cost_next;
            end
            if (load_edge || load_cost) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // weight RAM: write on load, read while scanning
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wmem[r_load_cnt[AW-1:0]] <= i_in.weight;
        end
        if (r_state == S_SCAN) begin
            r_rdata <= r_wmem[r_raddr];
        end
    end

    // scan counters
    always_ff @(posedge i_clk) begin
        if (r_state != S_SCAN) begin
            r_row   <= '0;
            r_col   <= '0;
            r_raddr <= '0;
        end else begin
            r_raddr <= r_raddr + AW'(1);
            if (r_col == nm1) begin
                r_col <= '0;
                r_row <= r_row + VW'(1);
            end else begin
                r_col <= r_col + VW'(1);
            end
        end
        r_prow <= r_row;
        r_pcol <= r_col;
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load_edge) begin
            r_okind <= KIND_EDGE;
            r_oa    <= a_ext[VTX_OUT_W-1:0];
            r_ob    <= b_ext[VTX_OUT_W-1:0];
            r_oamt  <= w_ext[AMOUNT_W-1:0];
            r_olast <= 1'b0;
        end else if (load_cost) begin
            r_okind <= KIND_COST;
            r_oa    <= '0;
            r_ob    <= '0;
            r_oamt  <= r_cost;
            r_olast <= 1'b1;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.kind     = r_okind;
    assign o_out.vertex_a = r_oa;
    assign o_out.vertex_b = r_ob;
    assign o_out.amount   = r_oamt;
    assign o_out.last     = r_olast;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    mstk_select #(
        .KEY_W (KEY_W)
    ) u_select (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sel_start),
        .i_commit   (sel_commit),
        .i_cand_vld (cand_vld),
        .i_cand_key (cand_key),
        .o_best_vld (best_vld),
        .o_best_key (best_key)
    );

    mstk_label #(
        .MAX_VERTICES (MAX_VERTICES),
        .VW           (VW)
    ) u_label (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lab_cmd),
        .i_va    (best_a),
        .i_vb    (best_b),
        .i_nm1   (nm1),
        .o_done  (lab_done),
        .o_same  (lab_same)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cost_returns_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_COST && out_free && !i_cfg_we)
            |=> (r_state == S_LOAD && r_load_cnt == '0 && r_cost == '0))
        else $error("run did not return to load after cost result");

    a_pick_is_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && best_vld)
            |-> (best_a < best_b && !best_w[WEIGHT_BITS-1] && best_w != '0))
        else $error("picked key is not an upper positive edge");

    a_scan_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !$past(i_cfg_we)) |-> (r_load_cnt == '0))
        else $error("load count left nonzero during solve");

endmodule
